// ===== rtl/mcm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types, constants and saturating helpers for the level-1 MOSFET
// companion model evaluator.
// ----------------------------------------------------------------------------
package mcm_pkg;

    // Fixed-point format of every value in the datapath
    localparam int VALUE_WIDTH   = 48;
    localparam int FRACTION_BITS = 32;

    // Configuration port geometry
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 48;
    localparam int VTH_WIDTH       = 48;
    localparam int GAIN_WIDTH      = 47;
    localparam int CLAMP_WIDTH     = VALUE_WIDTH + CFG_DATA_WIDTH;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    localparam t_value VMAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
    localparam t_value VMIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
    // 1.0, or the largest value when 1.0 does not fit the format
    localparam t_value UNITY = (FRACTION_BITS >= VALUE_WIDTH - 1) ? VMAX :
                               t_value'(64'd1 << FRACTION_BITS);

    typedef enum logic [1:0] {
        REG_CUTOFF = 2'd0,
        REG_CLAMP  = 2'd1,
        REG_LINEAR = 2'd2,
        REG_SAT    = 2'd3
    } t_region;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_POLARITY = 3'd0,
        CFG_VTH      = 3'd1,
        CFG_GAIN     = 3'd2,
        CFG_LAMBDA   = 3'd3
    } t_cfg_index;

    // Device settings as seen by the datapath
    typedef struct packed {
        logic   pol;
        t_value vth;
        t_value gain;
        t_value lambda;
    } t_cfg;

    // Bias point after region decode
    typedef struct packed {
        t_region region;
        t_value  vds;
        t_value  vgst;
        t_value  d;
    } t_front;

    // Saturating add
    function automatic t_value f_sadd(input t_value a, input t_value b);
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        end
        return t_value'(s[VALUE_WIDTH-1:0]);
    endfunction

    // Saturating subtract
    function automatic t_value f_ssub(input t_value a, input t_value b);
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
        if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
            return s[VALUE_WIDTH] ? VMIN : VMAX;
        end
        return t_value'(s[VALUE_WIDTH-1:0]);
    endfunction

    // Clamp a wide register value into the value range
    function automatic t_value f_clamp_cfg(input logic signed [CLAMP_WIDTH-1:0] x);
        if (x > CLAMP_WIDTH'(VMAX)) begin
            return VMAX;
        end
        if (x < CLAMP_WIDTH'(VMIN)) begin
            return VMIN;
        end
        return t_value'(x);
    endfunction

endpackage

// ===== rtl/mcm_cfg.sv =====
// ----------------------------------------------------------------------------
// mcm_cfg
// Device setting registers: polarity, threshold, gain and lambda, written
// through a valid/ready port and clamped into the value range.
// ----------------------------------------------------------------------------
module mcm_cfg import mcm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write transaction
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLARITY: n_cfg.pol = i_cfg_data[0];
                CFG_VTH: n_cfg.vth =
                    f_clamp_cfg(CLAMP_WIDTH'(signed'(i_cfg_data[VTH_WIDTH-1:0])));
                CFG_GAIN: n_cfg.gain =
                    f_clamp_cfg(CLAMP_WIDTH'(i_cfg_data[GAIN_WIDTH-1:0]));
                CFG_LAMBDA: n_cfg.lambda =
                    f_clamp_cfg(CLAMP_WIDTH'(i_cfg_data[GAIN_WIDTH-1:0]));
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

// ===== rtl/mcm_smul.sv =====
// ----------------------------------------------------------------------------
// mcm_smul
// Two-stage saturating fixed-point multiplier: half-width partial products
// in the first stage, sum, round half away from zero and saturate in the
// second.
// ----------------------------------------------------------------------------
module mcm_smul import mcm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en_a,
    input  logic   i_en_b,
    input  t_value i_a,
    input  t_value i_b,
    output t_value o_p
);

    localparam int LO_W   = (VALUE_WIDTH + 1) / 2;
    localparam int HI_W   = VALUE_WIDTH - LO_W;
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam logic [PROD_W-1:0] RND   = PROD_W'(1) << (FRACTION_BITS - 1);
    localparam logic [PROD_W-1:0] LIMIT = PROD_W'(unsigned'(VMAX));

    logic [VALUE_WIDTH-1:0] w_mag_a;
    logic [VALUE_WIDTH-1:0] w_mag_b;
    logic [2*LO_W-1:0]      r_ll;
    logic [LO_W+HI_W-1:0]   r_lh;
    logic [LO_W+HI_W-1:0]   r_hl;
    logic [2*HI_W-1:0]      r_hh;
    logic                   r_neg;
    logic [PROD_W-1:0]      w_sum;
    logic [PROD_W-1:0]      w_shift;
    logic [VALUE_WIDTH-1:0] w_mag_r;
    logic                   w_sat;
    t_value                 w_res;
    t_value                 r_p;

    // Take magnitudes
    always_comb begin
        w_mag_a = i_a[VALUE_WIDTH-1] ? unsigned'(-i_a) : unsigned'(i_a);
        w_mag_b = i_b[VALUE_WIDTH-1] ? unsigned'(-i_b) : unsigned'(i_b);
    end

    // Stage A: partial products
    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_ll  <= w_mag_a[LO_W-1:0] * w_mag_b[LO_W-1:0];
            r_lh  <= w_mag_a[LO_W-1:0] * w_mag_b[VALUE_WIDTH-1:LO_W];
            r_hl  <= w_mag_a[VALUE_WIDTH-1:LO_W] * w_mag_b[LO_W-1:0];
            r_hh  <= w_mag_a[VALUE_WIDTH-1:LO_W] * w_mag_b[VALUE_WIDTH-1:LO_W];
            r_neg <= i_a[VALUE_WIDTH-1] ^ i_b[VALUE_WIDTH-1];
        end
    end

    // Stage B: combine, round, saturate
    always_comb begin
        w_sum = (PROD_W'(r_hh) << (2 * LO_W)) + (PROD_W'(r_lh) << LO_W)
              + (PROD_W'(r_hl) << LO_W) + PROD_W'(r_ll) + RND;
        w_shift = w_sum >> FRACTION_BITS;
        w_sat   = w_shift > LIMIT;
        w_mag_r = w_shift[VALUE_WIDTH-1:0];
        if (r_neg) begin
            w_res = w_sat ? VMIN : -signed'(w_mag_r);
        end else begin
            w_res = w_sat ? VMAX : signed'(w_mag_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_p <= w_res;
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/mcm_front.sv =====
// ----------------------------------------------------------------------------
// mcm_front
// First two pipeline stages: overdrive voltage and cutoff/clamp test, then
// linear/saturation decision and Vgst - Vds.
// ----------------------------------------------------------------------------
module mcm_front import mcm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en1,
    input  logic   i_en2,
    input  t_cfg   i_cfg,
    input  t_value i_vgs,
    input  t_value i_vds,
    output t_front o_front
);

    typedef struct packed {
        logic   cut;
        logic   clamp;
        t_value vds;
        t_value vgst;
    } t_bias;

    t_bias  n_s1;
    t_bias  r_s1;
    t_front n_s2;
    t_front r_s2;
    logic   w_lin;

    // Stage 1: overdrive and early region tests
    always_comb begin
        n_s1.cut   = i_cfg.pol ? (i_vgs >= i_cfg.vth) : (i_vgs <= i_cfg.vth);
        n_s1.clamp = i_cfg.pol ? (!i_vds[VALUE_WIDTH-1] && (i_vds != '0))
                               : i_vds[VALUE_WIDTH-1];
        n_s1.vds   = i_vds;
        n_s1.vgst  = f_ssub(i_vgs, i_cfg.vth);
    end

    // Stage 2: final region and Vgst - Vds
    always_comb begin
        w_lin = i_cfg.pol ? (r_s1.vds >= r_s1.vgst) : (r_s1.vds <= r_s1.vgst);
        if (r_s1.cut) begin
            n_s2.region = REG_CUTOFF;
        end else if (r_s1.clamp) begin
            n_s2.region = REG_CLAMP;
        end else if (w_lin) begin
            n_s2.region = REG_LINEAR;
        end else begin
            n_s2.region = REG_SAT;
        end
        n_s2.vds  = r_s1.vds;
        n_s2.vgst = r_s1.vgst;
        n_s2.d    = f_ssub(r_s1.vgst, r_s1.vds);
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_s1 <= n_s1;
        end
        if (i_en2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_front = r_s2;

endmodule

// ===== rtl/mosfet_companion_model_eval_top.sv =====
// ----------------------------------------------------------------------------
// mosfet_companion_model_eval_top
// Level-1 square-law MOSFET evaluator for one Newton step: drain current,
// companion conductance, companion current and operating region.
// ----------------------------------------------------------------------------
// Usage:
//   Program polarity, threshold, gain and lambda through the cfg port
//   (valid/ready, index 0..3; other indexes are ignored) while no bias
//   point is in flight. The port is always ready.
//   Bias points (Vgs, Vds, signed Q16.32) enter on the input channel; one
//   transaction is taken at each edge with i_in_valid high and o_in_stall
//   low. Each produces exactly one result transaction on the output channel.
//   Throughput is one bias point per cycle while o_in_stall is low. The
//   pipeline depth comes from four dependent multiply rounds, each a two-stage
//   split multiplier, plus front decode, combine and output stages.
//   When the receiver holds i_out_stall, the output register holds its
//   transaction; earlier stages keep advancing into empty slots, and
//   o_in_stall rises only once every stage is occupied.
//   Synchronous active-low reset empties the pipeline and clears the
//   settings to zero.
// ----------------------------------------------------------------------------
module mosfet_companion_model_eval_top import mcm_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // bias point channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_gate_source_voltage,
    input  logic signed [VALUE_WIDTH-1:0] i_drain_source_voltage,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_drain_current,
    output logic signed [VALUE_WIDTH-1:0] o_equivalent_conductance,
    output logic signed [VALUE_WIDTH-1:0] o_equivalent_current,
    output logic [1:0]                   o_operating_region,
    // configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]    i_cfg_data
);

    localparam int NUM_STAGES = 13;

    typedef struct packed {
        t_region region;
        t_value  vds;
        t_value  m;
        t_value  qh;
        t_value  xb;
        t_value  xc;
        t_value  cur;
        t_value  g;
    } t_carry;

    t_cfg   w_cfg;
    t_front w_f2;

    logic [NUM_STAGES:1] r_vld;
    logic [NUM_STAGES:1] w_ready;

    t_carry n_c3, r_c3, r_c4;
    t_carry n_c5, r_c5, r_c6, r_c7;
    t_carry n_c8, r_c8, r_c9;
    t_carry n_c10, r_c10, r_c11, r_c12;

    t_value  w_sq_op;
    t_value  w_lv, w_vg, w_sq, w_kl, w_kd;
    t_value  w_half;
    t_value  w_x2a, w_x2b, w_x2c;
    t_value  w_y3a, w_y3b;
    t_value  w_gv;

    t_value  r_out_cur;
    t_value  r_out_g;
    t_value  r_out_ieq;
    t_region r_out_region;

    // Settings registers
    mcm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Compute per-stage ready: a stage loads when empty or when it drains
    always_comb begin
        w_ready[NUM_STAGES] = !r_vld[NUM_STAGES] || !i_out_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k + 1];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ready[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (w_ready[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    assign o_in_stall = !w_ready[1];

    // Stages 1-2: region decode
    mcm_front u_front (
        .i_clk   (i_clk),
        .i_en1   (w_ready[1]),
        .i_en2   (w_ready[2]),
        .i_cfg   (w_cfg),
        .i_vgs   (i_gate_source_voltage),
        .i_vds   (i_drain_source_voltage),
        .o_front (w_f2)
    );

    // Round 1 multiplies (stages 3-4)
    assign w_sq_op = (w_f2.region == REG_LINEAR) ? w_f2.vds : w_f2.vgst;

    mcm_smul u_mul_lv (
        .i_clk (i_clk), .i_en_a (w_ready[3]), .i_en_b (w_ready[4]),
        .i_a (w_cfg.lambda), .i_b (w_f2.vds), .o_p (w_lv)
    );
    mcm_smul u_mul_vg (
        .i_clk (i_clk), .i_en_a (w_ready[3]), .i_en_b (w_ready[4]),
        .i_a (w_f2.vds), .i_b (w_f2.vgst), .o_p (w_vg)
    );
    mcm_smul u_mul_sq (
        .i_clk (i_clk), .i_en_a (w_ready[3]), .i_en_b (w_ready[4]),
        .i_a (w_sq_op), .i_b (w_sq_op), .o_p (w_sq)
    );
    mcm_smul u_mul_kl (
        .i_clk (i_clk), .i_en_a (w_ready[3]), .i_en_b (w_ready[4]),
        .i_a (w_cfg.gain), .i_b (w_cfg.lambda), .o_p (w_kl)
    );
    mcm_smul u_mul_kd (
        .i_clk (i_clk), .i_en_a (w_ready[3]), .i_en_b (w_ready[4]),
        .i_a (w_cfg.gain), .i_b (w_f2.d), .o_p (w_kd)
    );

    always_comb begin
        n_c3        = '0;
        n_c3.region = w_f2.region;
        n_c3.vds    = w_f2.vds;
    end

    // Stage 5: modulation factor and q (linear) or half square (saturation)
    assign w_half = w_sq >>> 1;

    always_comb begin
        n_c5    = r_c4;
        n_c5.m  = w_cfg.pol ? f_ssub(UNITY, w_lv) : f_sadd(UNITY, w_lv);
        n_c5.qh = (r_c4.region == REG_LINEAR) ? f_ssub(w_vg, w_half) : w_half;
        n_c5.xb = w_kd;
        n_c5.xc = w_kl;
    end

    // Round 2 multiplies (stages 6-7)
    mcm_smul u_mul_kq (
        .i_clk (i_clk), .i_en_a (w_ready[6]), .i_en_b (w_ready[7]),
        .i_a (w_cfg.gain), .i_b (r_c5.qh), .o_p (w_x2a)
    );
    mcm_smul u_mul_b (
        .i_clk (i_clk), .i_en_a (w_ready[6]), .i_en_b (w_ready[7]),
        .i_a (r_c5.xb), .i_b (r_c5.m), .o_p (w_x2b)
    );
    mcm_smul u_mul_c (
        .i_clk (i_clk), .i_en_a (w_ready[6]), .i_en_b (w_ready[7]),
        .i_a (r_c5.xc), .i_b (r_c5.qh), .o_p (w_x2c)
    );

    // Stage 8: capture conductance terms
    always_comb begin
        n_c8    = r_c7;
        n_c8.xb = w_x2b;
        n_c8.xc = w_x2c;
    end

    // Round 3 multiplies (stages 8-9)
    mcm_smul u_mul_a (
        .i_clk (i_clk), .i_en_a (w_ready[8]), .i_en_b (w_ready[9]),
        .i_a (w_x2a), .i_b (r_c7.m), .o_p (w_y3a)
    );
    mcm_smul u_mul_hl (
        .i_clk (i_clk), .i_en_a (w_ready[8]), .i_en_b (w_ready[9]),
        .i_a (w_x2a), .i_b (w_cfg.lambda), .o_p (w_y3b)
    );

    // Stage 10: current and conductance per region
    always_comb begin
        n_c10 = r_c9;
        case (r_c9.region)
            REG_CUTOFF: begin
                n_c10.cur = '0;
                n_c10.g   = '0;
            end
            REG_CLAMP: begin
                n_c10.cur = r_c9.vds;
                n_c10.g   = UNITY;
            end
            REG_LINEAR: begin
                n_c10.cur = w_cfg.pol ? f_ssub('0, w_y3a) : w_y3a;
                n_c10.g   = w_cfg.pol ? f_ssub(r_c9.xc, r_c9.xb)
                                      : f_sadd(r_c9.xc, r_c9.xb);
            end
            REG_SAT: begin
                n_c10.cur = w_cfg.pol ? f_ssub('0, w_y3a) : w_y3a;
                n_c10.g   = w_y3b;
            end
            default: begin
                n_c10.cur = '0;
                n_c10.g   = '0;
            end
        endcase
    end

    // Round 4 multiply (stages 11-12): G * Vds
    mcm_smul u_mul_gv (
        .i_clk (i_clk), .i_en_a (w_ready[11]), .i_en_b (w_ready[12]),
        .i_a (r_c10.g), .i_b (r_c10.vds), .o_p (w_gv)
    );

    // Advance payload registers
    always_ff @(posedge i_clk) begin
        if (w_ready[3])  r_c3  <= n_c3;
        if (w_ready[4])  r_c4  <= r_c3;
        if (w_ready[5])  r_c5  <= n_c5;
        if (w_ready[6])  r_c6  <= r_c5;
        if (w_ready[7])  r_c7  <= r_c6;
        if (w_ready[8])  r_c8  <= n_c8;
        if (w_ready[9])  r_c9  <= r_c8;
        if (w_ready[10]) r_c10 <= n_c10;
        if (w_ready[11]) r_c11 <= r_c10;
        if (w_ready[12]) r_c12 <= r_c11;
    end

    // Stage 13: companion current into the output register
    always_ff @(posedge i_clk) begin
        if (w_ready[NUM_STAGES]) begin
            r_out_cur    <= r_c12.cur;
            r_out_g      <= r_c12.g;
            r_out_ieq    <= f_ssub(r_c12.cur, w_gv);
            r_out_region <= r_c12.region;
        end
    end

    assign o_out_valid              = r_vld[NUM_STAGES];
    assign o_drain_current          = r_out_cur;
    assign o_equivalent_conductance = r_out_g;
    assign o_equivalent_current     = r_out_ieq;
    assign o_operating_region       = r_out_region;

    // Input stalls only when every stage holds a transaction and output waits
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&r_vld) && i_out_stall))
        else $error("input stalled while the pipeline has a free slot");

    // Cutoff gives all-zero currents and conductance
    a_cutoff_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_operating_region == REG_CUTOFF)) |->
        ((o_drain_current == '0) && (o_equivalent_conductance == '0) &&
         (o_equivalent_current == '0)))
        else $error("nonzero result in cutoff");

    // Reverse-bias clamp drives unit conductance
    a_clamp_unity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_operating_region == REG_CLAMP)) |->
        (o_equivalent_conductance == UNITY))
        else $error("clamp conductance is not unity");

    // Reset empties the pipeline
    a_reset_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule
